// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPSA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define IPSA_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IPSA_ASSERT(lbl, clk, rst_n, prop)
`define IPSA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/ipsa_pkg.sv -----
// Types, constants and helpers shared by the IPS patch applier.
package ipsa_pkg;

  localparam logic [23:0] EOF_MARK  = 24'h454F46;
  localparam logic [3:0]  MIN_LEN   = 4'd8;
  localparam logic [2:0]  HDR_LAST  = 3'd4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam logic [24:0] IMAGE_SIZE_RESET = 25'd6291456;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OFFSET,
    PH_LENGTH,
    PH_RLE,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_BOUNDS = 2'd2,
    ERR_UNTERM = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] address;
    logic [7:0]  data;
    logic [15:0] fill_count;
    err_e        error_code;
    logic        run_last;
  } result_t;

  // Up to two results produced by one patch byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h50;
      3'd1:    val = 8'h41;
      3'd2:    val = 8'h54;
      3'd3:    val = 8'h43;
      3'd4:    val = 8'h48;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic result_t finish_res(input err_e err);
    result_t r;
    r            = '0;
    r.kind       = KIND_FINISH;
    r.error_code = err;
    return r;
  endfunction

endpackage

// ----- hdl/ipsa_parser.sv -----
// Record parser: holds the parse state and turns one patch byte into results.
module ipsa_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      patch_byte_i,
  input  logic            last_byte_i,
  input  logic [24:0]     image_size_i,
  output ipsa_pkg::push_t push_o
);
  import ipsa_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  fi_q, fi_d;
  logic [3:0]  sc_q, sc_d;
  logic        fin_q, fin_d;
  logic [23:0] off_q, off_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] rc_q, rc_d;
  logic [23:0] wa_q, wa_d;

  logic [3:0]  sc_n;
  logic        short_last;
  logic [23:0] off_n;
  logic [15:0] rem_n;
  logic [15:0] rc_n;
  logic [15:0] rem_dec;
  logic        hdr_bad;
  logic        len_over;
  logic        rle_over;
  logic        done_c;
  push_t       push_c;

  assign sc_n       = (sc_q < MIN_LEN) ? sc_q + 4'd1 : sc_q;
  assign short_last = last_byte_i && (sc_n < MIN_LEN);
  assign off_n      = {off_q[15:0], patch_byte_i};
  assign rem_n      = {rem_q[7:0], patch_byte_i};
  assign rc_n       = {rc_q[7:0], patch_byte_i};
  assign rem_dec    = rem_q - 16'd1;
  assign hdr_bad    = (fi_q > HDR_LAST) || (patch_byte_i != magic_byte(fi_q));
  assign len_over   = ({1'b0, off_q} + {9'b0, rem_n}) > image_size_i;
  assign rle_over   = ({1'b0, off_q} + {9'b0, rc_q}) > image_size_i;

  // Results of the byte being accepted.
  always_comb begin
    push_c = '0;
    done_c = 1'b0;
    if (accept_i && !fin_q) begin
      if (short_last) begin
        push_c.r0    = finish_res(ERR_HEADER);
        push_c.count = 2'd1;
        done_c       = 1'b1;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (hdr_bad) begin
              push_c.r0    = finish_res(ERR_HEADER);
              push_c.count = 2'd1;
              done_c       = 1'b1;
            end
          end
          PH_OFFSET: begin
            if (fi_q >= 3'd2 && off_n == EOF_MARK) begin
              push_c.r0    = finish_res(ERR_OK);
              push_c.count = 2'd1;
              done_c       = 1'b1;
            end
          end
          PH_LENGTH: begin
            if (fi_q >= 3'd1 && rem_n != '0 && (len_over || last_byte_i)) begin
              push_c.r0    = finish_res(ERR_BOUNDS);
              push_c.count = 2'd1;
              done_c       = 1'b1;
            end
          end
          PH_RLE: begin
            if (fi_q >= 3'd2) begin
              if (rle_over) begin
                push_c.r0    = finish_res(ERR_BOUNDS);
                done_c       = 1'b1;
              end else begin
                push_c.r0.kind       = KIND_FILL;
                push_c.r0.address    = off_q;
                push_c.r0.data       = patch_byte_i;
                push_c.r0.fill_count = rc_q;
              end
              push_c.count = 2'd1;
            end
          end
          PH_DATA: begin
            push_c.r0.kind    = KIND_WRITE;
            push_c.r0.address = wa_q;
            push_c.r0.data    = patch_byte_i;
            push_c.count      = 2'd1;
            if (last_byte_i) begin
              push_c.r1    = finish_res((rem_dec == '0) ? ERR_UNTERM : ERR_BOUNDS);
              push_c.count = 2'd2;
              done_c       = 1'b1;
            end
          end
          default: ;
        endcase
        // Stream ends inside a record: close it as unterminated.
        if (last_byte_i && !done_c) begin
          if (push_c.count == 2'd0) begin
            push_c.r0 = finish_res(ERR_UNTERM);
          end else begin
            push_c.r1 = finish_res(ERR_UNTERM);
          end
          push_c.count = push_c.count + 2'd1;
          done_c       = 1'b1;
        end
      end
      if (push_c.count == 2'd1) push_c.r0.run_last = 1'b1;
      if (push_c.count == 2'd2) push_c.r1.run_last = 1'b1;
    end
  end

  assign push_o = push_c;

  // Next parse state.
  always_comb begin
    phase_d = phase_q;
    fi_d    = fi_q;
    sc_d    = sc_q;
    fin_d   = fin_q;
    off_d   = off_q;
    rem_d   = rem_q;
    rc_d    = rc_q;
    wa_d    = wa_q;
    if (accept_i && !fin_q) begin
      sc_d = sc_n;
      if (!short_last) begin
        unique case (phase_q)
          PH_HEADER: begin
            if (!hdr_bad) begin
              if (fi_q == HDR_LAST) begin
                phase_d = PH_OFFSET;
                fi_d    = '0;
              end else begin
                fi_d = fi_q + 3'd1;
              end
            end
          end
          PH_OFFSET: begin
            off_d = off_n;
            if (fi_q >= 3'd2) begin
              fi_d = '0;
              if (off_n != EOF_MARK) phase_d = PH_LENGTH;
            end else begin
              fi_d = fi_q + 3'd1;
            end
          end
          PH_LENGTH: begin
            rem_d = rem_n;
            if (fi_q >= 3'd1) begin
              fi_d = '0;
              if (rem_n == '0) begin
                phase_d = PH_RLE;
              end else if (!(len_over || last_byte_i)) begin
                phase_d = PH_DATA;
                wa_d    = off_q;
              end
            end else begin
              fi_d = fi_q + 3'd1;
            end
          end
          PH_RLE: begin
            if (fi_q < 3'd2) begin
              rc_d = rc_n;
              fi_d = fi_q + 3'd1;
            end else begin
              fi_d = '0;
              if (!rle_over) phase_d = PH_OFFSET;
            end
          end
          PH_DATA: begin
            wa_d  = wa_q + 24'd1;
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_OFFSET;
              fi_d    = '0;
            end
          end
          default: begin
            phase_d = PH_OFFSET;
            fi_d    = '0;
          end
        endcase
      end
      if (!last_byte_i && done_c) fin_d = 1'b1;
    end
    // Rearm for a fresh patch on every last byte.
    if (accept_i && last_byte_i) begin
      phase_d = PH_HEADER;
      fi_d    = '0;
      sc_d    = '0;
      fin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      fi_q    <= '0;
      sc_q    <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fi_q    <= fi_d;
      sc_q    <= sc_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    rem_q <= rem_d;
    rc_q  <= rc_d;
    wa_q  <= wa_d;
  end

endmodule

// ----- hdl/ipsa_out_fifo.sv -----
// Result queue: takes up to two results a cycle, delivers one per transaction.
module ipsa_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipsa_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipsa_pkg::result_t head_o
);
  import ipsa_pkg::*;

  localparam logic [OUT_PTR_W:0] DEPTH_C = (OUT_PTR_W + 1)'(OUT_DEPTH);

  result_t              mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_q, wr_d;
  logic [OUT_PTR_W-1:0] rd_q, rd_d;
  logic [OUT_PTR_W:0]   cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0] wr_next;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= DEPTH_C - (OUT_PTR_W + 1)'(2));
  assign head_o      = mem_q[rd_q];
  assign wr_next     = wr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_d  = wr_q + OUT_PTR_W'(push_i.count);
    rd_d  = pop ? rd_q + OUT_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (OUT_PTR_W + 1)'(push_i.count) - (OUT_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.r1;
  end

endmodule

// ----- hdl/ips_patch_stream_applier_top.sv -----
// Top level of the IPS patch stream applier.
//
// Input channel (in_valid_i/in_ready_o) carries one patch byte per transaction,
// with last_byte_i on the final byte. Output channel (out_valid_o/out_ready_i)
// carries results: byte writes, fill runs and one finish result per patch with
// its error code; run_last_o marks the last result caused by one byte.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the image size; it is
// always ready and should only be written while the block is idle.
// A byte is parsed in the cycle it is accepted; its results pass through the
// result queue to the output. One byte is taken per cycle while there is room;
// a byte with two results takes two entries of the four-entry result queue.
// in_ready_o drops while the queue has fewer than two free entries, so a
// stalled receiver backs up into the input channel without losing results.
// Reset empties the queue, returns the parser to the header phase and sets
// the image size to 6291456.
module ips_patch_stream_applier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  patch_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [23:0] address_o,
  output logic [7:0]  data_o,
  output logic [15:0] fill_count_o,
  output logic [1:0]  error_code_o,
  output logic        run_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [24:0] image_size_i
);
  import ipsa_pkg::*;

  `include "assert_macros.svh"

  logic [24:0] image_size_q;
  logic        accept;
  logic        room;
  push_t       push;
  result_t     head;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = room;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= IMAGE_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      image_size_q <= image_size_i;
    end
  end

  ipsa_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .patch_byte_i (patch_byte_i),
    .last_byte_i  (last_byte_i),
    .image_size_i (image_size_q),
    .push_o       (push)
  );

  ipsa_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign address_o    = head.address;
  assign data_o       = head.data;
  assign fill_count_o = head.fill_count;
  assign error_code_o = head.error_code;
  assign run_last_o   = head.run_last;

  `IPSA_ASSERT(a_empty_is_ready, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `IPSA_ASSERT(a_err_on_finish_only, clk_i, rst_ni,
    (out_valid_o && kind_o != KIND_FINISH) |-> error_code_o == ERR_OK)
  `IPSA_ASSERT(a_write_no_count, clk_i, rst_ni,
    (out_valid_o && kind_o == KIND_WRITE) |-> fill_count_o == 16'd0)
  `IPSA_ASSERT(a_finish_is_last, clk_i, rst_ni,
    (out_valid_o && kind_o == KIND_FINISH) |-> run_last_o)

endmodule
